// ===== sv/artdmx_pkg.sv =====
package artdmx_pkg;

	localparam int MAX_SLOTS_DEF = 512;
	localparam int SLOT_COUNT_W  = 10;
	localparam int UNIVERSE_W    = 16;
	localparam int POS_W         = 11;
	localparam int POS_MAX       = 2047;
	localparam int HDR_LEN       = 18;
	localparam int ID_LEN        = 7;
	localparam int POS_OPCODE_HI = 8;
	localparam int POS_OPCODE_LO = 9;
	localparam int POS_UNI_LO    = 14;
	localparam int POS_UNI_HI    = 15;
	localparam int POS_LEN_HI    = 16;
	localparam int POS_LEN_LO    = 17;

	localparam logic [7:0] OPCODE_HI = 8'h00;
	localparam logic [7:0] OPCODE_LO = 8'h50;

	localparam logic ACT_BYTE  = 1'b0;
	localparam logic ACT_FETCH = 1'b1;

	localparam logic KIND_DMX    = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [2:0] {
		ST_ACCEPTED       = 3'd0,
		ST_TOO_SHORT      = 3'd1,
		ST_BAD_ID         = 3'd2,
		ST_BAD_OPCODE     = 3'd3,
		ST_OTHER_UNIVERSE = 3'd4,
		ST_TRUNCATED      = 3'd5
	} status_t;

	// packet end report from the receive side
	typedef struct packed {
		logic                    valid;
		status_t                 status;
		logic [SLOT_COUNT_W-1:0] slot_count;
	} rx_report_t;

	// one served fetch from the drain side
	typedef struct packed {
		logic valid;
		logic start;
		logic last;
		logic rd;
	} dmx_req_t;

	// "Art-Net" identifier text
	function automatic logic [7:0] id_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h41;
			3'd1: c = 8'h72;
			3'd2: c = 8'h74;
			3'd3: c = 8'h2D;
			3'd4: c = 8'h4E;
			3'd5: c = 8'h65;
			3'd6: c = 8'h74;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== sv/artdmx_ram.sv =====
module artdmx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/artdmx_rx.sv =====
module artdmx_rx #(
	parameter int MAX_SLOTS = artdmx_pkg::MAX_SLOTS_DEF,
	parameter int BANK_AW   = 9
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 take_byte,
	input  logic [7:0]                           data_byte,
	input  logic                                 packet_end,
	input  logic [artdmx_pkg::UNIVERSE_W-1:0]    universe,
	input  logic                                 drain_bank,
	output logic                                 mem_we,
	output logic [BANK_AW:0]                     mem_waddr,
	output logic [7:0]                           mem_wdata,
	output artdmx_pkg::rx_report_t               report
);

	localparam int CNT_W = $clog2(MAX_SLOTS + 1);
	localparam int POS_W = artdmx_pkg::POS_W;
	localparam int UNI_W = artdmx_pkg::UNIVERSE_W;

	logic [POS_W-1:0]    pos_q, pos_n, off;
	artdmx_pkg::status_t fault_q, fault_n, status;
	logic [UNI_W-1:0]    uni_q, uni_n;
	logic [15:0]         len_q, len_n;
	logic [CNT_W-1:0]    len_c;

	always_comb begin
		pos_n   = (pos_q == POS_W'(artdmx_pkg::POS_MAX)) ? pos_q : pos_q + 1'b1;
		fault_n = fault_q;
		uni_n   = uni_q;
		len_n   = len_q;
		mem_we  = 1'b0;
		off     = pos_q - POS_W'(artdmx_pkg::HDR_LEN);
		if (pos_q < POS_W'(artdmx_pkg::ID_LEN)) begin
			if (data_byte != artdmx_pkg::id_char(pos_q[2:0]) &&
			    fault_q == artdmx_pkg::ST_ACCEPTED) begin
				fault_n = artdmx_pkg::ST_BAD_ID;
			end
		end else if (pos_q == POS_W'(artdmx_pkg::POS_OPCODE_HI)) begin
			if (data_byte != artdmx_pkg::OPCODE_HI && fault_q == artdmx_pkg::ST_ACCEPTED) begin
				fault_n = artdmx_pkg::ST_BAD_OPCODE;
			end
		end else if (pos_q == POS_W'(artdmx_pkg::POS_OPCODE_LO)) begin
			if (data_byte != artdmx_pkg::OPCODE_LO && fault_q == artdmx_pkg::ST_ACCEPTED) begin
				fault_n = artdmx_pkg::ST_BAD_OPCODE;
			end
		end else if (pos_q == POS_W'(artdmx_pkg::POS_UNI_LO)) begin
			uni_n = {uni_q[15:8], data_byte};
		end else if (pos_q == POS_W'(artdmx_pkg::POS_UNI_HI)) begin
			uni_n = {data_byte, uni_q[7:0]};
		end else if (pos_q == POS_W'(artdmx_pkg::POS_LEN_HI)) begin
			len_n = {data_byte, len_q[7:0]};
		end else if (pos_q == POS_W'(artdmx_pkg::POS_LEN_LO)) begin
			len_n = {len_q[15:8], data_byte};
		end else if (pos_q >= POS_W'(artdmx_pkg::HDR_LEN) && off < POS_W'(MAX_SLOTS)) begin
			mem_we = take_byte;
		end
	end

	// write into the bank that is not being drained
	assign mem_waddr = {~drain_bank, off[BANK_AW-1:0]};
	assign mem_wdata = data_byte;

	always_comb begin
		len_c = (len_n > 16'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : len_n[CNT_W-1:0];
		if (pos_n <= POS_W'(artdmx_pkg::HDR_LEN)) begin
			status = artdmx_pkg::ST_TOO_SHORT;
		end else if (fault_n != artdmx_pkg::ST_ACCEPTED) begin
			status = fault_n;
		end else if (uni_n != universe) begin
			status = artdmx_pkg::ST_OTHER_UNIVERSE;
		end else if ((12'(artdmx_pkg::HDR_LEN) + 12'(len_c)) > 12'(pos_n)) begin
			status = artdmx_pkg::ST_TRUNCATED;
		end else begin
			status = artdmx_pkg::ST_ACCEPTED;
		end
		report.valid      = take_byte & packet_end;
		report.status     = status;
		report.slot_count = (status == artdmx_pkg::ST_ACCEPTED) ?
			artdmx_pkg::SLOT_COUNT_W'(len_c) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			fault_q <= artdmx_pkg::ST_ACCEPTED;
			uni_q   <= '0;
			len_q   <= '0;
		end else if (take_byte) begin
			if (packet_end) begin
				pos_q   <= '0;
				fault_q <= artdmx_pkg::ST_ACCEPTED;
				uni_q   <= '0;
				len_q   <= '0;
			end else begin
				pos_q   <= pos_n;
				fault_q <= fault_n;
				uni_q   <= uni_n;
				len_q   <= len_n;
			end
		end
	end

endmodule

// ===== sv/artdmx_drain.sv =====
module artdmx_drain #(
	parameter int MAX_SLOTS = artdmx_pkg::MAX_SLOTS_DEF,
	parameter int BANK_AW   = 9
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fetch,
	input  artdmx_pkg::rx_report_t report,
	output logic                   drain_bank,
	output logic                   mem_re,
	output logic [BANK_AW:0]       mem_raddr,
	output artdmx_pkg::dmx_req_t   req
);

	localparam int CNT_W = $clog2(MAX_SLOTS + 1);

	logic             bank_q;
	logic             pending_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] len_q;
	logic [CNT_W-1:0] rd_off;
	logic             commit;

	assign commit = report.valid && report.status == artdmx_pkg::ST_ACCEPTED;

	always_comb begin
		req.valid = fetch & pending_q;
		req.start = (idx_q == '0);
		req.last  = (idx_q >= len_q);
		req.rd    = (idx_q != '0);
		rd_off    = idx_q - 1'b1;
	end

	// slot k of the frame sits at offset k-1; index 0 is the start code
	assign mem_re     = req.valid & req.rd;
	assign mem_raddr  = {bank_q, rd_off[BANK_AW-1:0]};
	assign drain_bank = bank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q    <= 1'b0;
			pending_q <= 1'b0;
			idx_q     <= '0;
			len_q     <= '0;
		end else if (commit) begin
			bank_q    <= ~bank_q;
			pending_q <= 1'b1;
			idx_q     <= '0;
			len_q     <= report.slot_count[CNT_W-1:0];
		end else if (req.valid) begin
			if (req.last) begin
				pending_q <= 1'b0;
				idx_q     <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

// ===== sv/artdmx_packet_to_dmx_frame.sv =====
// ArtDMX packet receiver with double-buffered DMX512 frame output. Packet bytes
// (action 0) and fetch requests (action 1) share the input channel; one item is
// taken per cycle unless in_stall is high. Header bytes are checked on the fly,
// payload bytes go into the receive half of a two-bank slot RAM, and the last
// byte of a packet yields one status transaction. An accepted packet swaps the
// banks and restarts the drain, after which each fetch returns the start code
// and then one slot. A result is registered in stage 2, beside the registered
// RAM read, then in the output register. Stage 2 keeps input taking while a
// result waits, so sustained rate is one item per cycle as long as the output
// is not stalled. A fetch with no frame armed, and any packet byte but the last,
// give no result. The universe register may be written only while no
// transaction is in flight.
module artdmx_packet_to_dmx_frame #(
	parameter int MAX_SLOTS = artdmx_pkg::MAX_SLOTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [artdmx_pkg::UNIVERSE_W-1:0]   cfg_wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                action,
	input  logic [7:0]                          data_byte,
	input  logic                                packet_end,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                kind,
	output logic [2:0]                          status,
	output logic [artdmx_pkg::SLOT_COUNT_W-1:0] slot_count,
	output logic [7:0]                          dmx_byte,
	output logic                                is_start_code,
	output logic                                frame_last
);

	localparam int BANK_AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int RAM_DEPTH = 2 * (2 ** BANK_AW);

	logic [artdmx_pkg::UNIVERSE_W-1:0] universe_q;

	logic                   accept, take_byte, fetch;
	logic                   drain_bank;
	logic                   mem_we, mem_re;
	logic [BANK_AW:0]       mem_waddr, mem_raddr;
	logic [7:0]             mem_wdata, mem_rdata;
	artdmx_pkg::rx_report_t report;
	artdmx_pkg::dmx_req_t   req;

	logic                                valid_s2, kind_s2, start_s2, last_s2, rd_s2;
	artdmx_pkg::status_t                 status_s2;
	logic [artdmx_pkg::SLOT_COUNT_W-1:0] count_s2;
	logic                                out_ready, s2_move, s2_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			universe_q <= '0;
		end else if (cfg_wr_en) begin
			universe_q <= cfg_wr_data;
		end
	end

	assign out_ready = !out_valid || !out_stall;
	assign s2_move   = valid_s2 & out_ready;
	assign in_stall  = valid_s2 & ~out_ready;
	assign accept    = in_valid & ~in_stall;
	assign take_byte = accept && action == artdmx_pkg::ACT_BYTE;
	assign fetch     = accept && action == artdmx_pkg::ACT_FETCH;
	assign s2_load   = report.valid | req.valid;

	artdmx_rx #(
		.MAX_SLOTS (MAX_SLOTS),
		.BANK_AW   (BANK_AW)
	) u_rx (
		.clk        (clk),
		.arst_n     (arst_n),
		.take_byte  (take_byte),
		.data_byte  (data_byte),
		.packet_end (packet_end),
		.universe   (universe_q),
		.drain_bank (drain_bank),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.report     (report)
	);

	artdmx_drain #(
		.MAX_SLOTS (MAX_SLOTS),
		.BANK_AW   (BANK_AW)
	) u_drain (
		.clk        (clk),
		.arst_n     (arst_n),
		.fetch      (fetch),
		.report     (report),
		.drain_bank (drain_bank),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.req        (req)
	);

	// read data holds until the next read, which only comes when s2 is empty or moves
	artdmx_ram #(
		.WIDTH (8),
		.DEPTH (RAM_DEPTH)
	) u_slot_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (accept) begin
			valid_s2 <= s2_load;
		end else if (s2_move) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (report.valid) begin
				kind_s2   <= artdmx_pkg::KIND_STATUS;
				status_s2 <= report.status;
				count_s2  <= report.slot_count;
				start_s2  <= 1'b0;
				last_s2   <= 1'b0;
				rd_s2     <= 1'b0;
			end else begin
				kind_s2   <= artdmx_pkg::KIND_DMX;
				status_s2 <= artdmx_pkg::ST_ACCEPTED;
				count_s2  <= '0;
				start_s2  <= req.start;
				last_s2   <= req.last;
				rd_s2     <= req.rd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_ready) begin
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			kind          <= kind_s2;
			status        <= status_s2;
			slot_count    <= count_s2;
			dmx_byte      <= rd_s2 ? mem_rdata : 8'h00;
			is_start_code <= start_s2;
			frame_last    <= last_s2;
		end
	end

endmodule
